>>> design/wts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_pkg
// Shared constants, lobe fit coefficients, colour matrix and pipeline
// stage records for the wavelength to sRGB converter.
// ----------------------------------------------------------------------------
package wts_pkg;

   localparam int unsigned FRAC_BITS    = 16;
   localparam int unsigned ARG_W        = 42;
   localparam int unsigned TAYLOR_TERMS = 13;
   localparam int unsigned EXP_SAT      = 40;
   localparam int unsigned ROOT_STEPS   = 30;
   localparam int unsigned NUM_LOBES    = 7;

   localparam int unsigned EXP_LAT   = 1 + 3 * TAYLOR_TERMS + (EXP_SAT - 1);
   localparam int unsigned LOBE_LAT  = 6 + EXP_LAT;
   localparam int unsigned MIX_LAT   = 6;
   localparam int unsigned ENC_LAT   = 7 + ROOT_STEPS + EXP_LAT;
   localparam int unsigned TOTAL_LAT = 1 + LOBE_LAT + MIX_LAT + ENC_LAT;

   localparam logic [29:0] INV_E_Q30 = 30'd395007542;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;

   localparam logic [13:0] W_MIN = 14'd3000;
   localparam logic [13:0] W_MAX = 14'd9000;

   localparam logic [16:0] ONE_Q    = 17'(64'd1 << FRAC_BITS);
   localparam logic [16:0] LIN_KNEE = 17'((64'd31308 << FRAC_BITS) / 64'd10000000);

   localparam logic [12:0] LOBE_CENTRE [0:NUM_LOBES-1] =
      '{13'd4420, 13'd5998, 13'd5011, 13'd5688, 13'd5309, 13'd4370, 13'd4590};
   localparam logic [9:0]  LOBE_K_BELOW [0:NUM_LOBES-1] =
      '{10'd624, 10'd264, 10'd490, 10'd213, 10'd613, 10'd845, 10'd385};
   localparam logic [9:0]  LOBE_K_ABOVE [0:NUM_LOBES-1] =
      '{10'd374, 10'd323, 10'd382, 10'd247, 10'd322, 10'd278, 10'd725};
   localparam logic signed [12:0] LOBE_WEIGHT [0:NUM_LOBES-1] =
      '{13'sd362, 13'sd1056, -13'sd65, 13'sd821, 13'sd286, 13'sd1217, 13'sd681};

   localparam logic signed [26:0] RGB_MATRIX [0:2][0:2] = '{
      '{ 27'sd32406255, -27'sd15372080, -27'sd4986286},
      '{-27'sd9689307,   27'sd18757561,  27'sd415175},
      '{ 27'sd557101,   -27'sd2040211,   27'sd10569959}
   };

   typedef logic [16:0] q_unsigned_type;

   typedef struct packed {
      logic [5:0]  n;
      logic        z;
      logic [29:0] f;
      logic [31:0] sum;
      logic [30:0] term;
   } exp_state_type;

   typedef struct packed {
      logic [4:0]  e;
      logic [30:0] m;
      logic [29:0] bits;
   } root_state_type;

   typedef struct packed {
      logic       knee;
      logic [7:0] lin_pre;
   } knee_type;

endpackage
`default_nettype wire

>>> design/wts_exp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_exp
// Pipelined exp(-a) in Q30: one Taylor term per three stages for the
// fraction, then one stage per step of the 1/e product for the integer part.
// ----------------------------------------------------------------------------
module wts_exp
   import wts_pkg::*;
(
   input  logic             clock,
   input  logic [ARG_W-1:0] arg,
   output logic [30:0]      result
);

   exp_state_type st_ff   [0:TAYLOR_TERMS];
   exp_state_type st_a_ff [1:TAYLOR_TERMS];
   exp_state_type st_b_ff [1:TAYLOR_TERMS];
   logic [30:0]   x_ff    [1:TAYLOR_TERMS];
   logic [30:0]   xb_ff   [1:TAYLOR_TERMS];
   logic [62:0]   y_ff    [1:TAYLOR_TERMS];
   exp_state_type pw_ff   [1:EXP_SAT-1];
   exp_state_type st0_in;

   always_comb begin
      st0_in.n    = arg[35:30];
      st0_in.z    = (arg[ARG_W-1:30] >= (ARG_W-30)'(EXP_SAT));
      st0_in.f    = arg[29:0];
      st0_in.sum  = 32'h4000_0000;
      st0_in.term = 31'h4000_0000;
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= st0_in;
   end

   for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
      localparam logic [31:0] RECIP = 32'((64'd1 << 31) / k);
      localparam logic [3:0]  STEP  = 4'(k);
      logic [63:0]   prod;
      logic [30:0]   x_in;
      logic [30:0]   q0;
      logic [34:0]   rem;
      logic [30:0]   q;
      exp_state_type st_in;

      always_comb begin
         prod = 64'(st_ff[k-1].term) * 64'(st_ff[k-1].f);
         x_in = prod[60:30];
      end

      always_comb begin
         q0  = y_ff[k][61:31];
         rem = 35'(xb_ff[k]) - 35'(q0) * 35'(STEP);
         q   = q0 + 31'(rem >= 35'(STEP));
         st_in      = st_b_ff[k];
         st_in.term = q;
         if ((k % 2) == 1) begin
            st_in.sum = (32'(q) > st_b_ff[k].sum) ? 32'd0 : st_b_ff[k].sum - 32'(q);
         end else begin
            st_in.sum = st_b_ff[k].sum + 32'(q);
         end
      end

      always_ff @(posedge clock) begin
         st_a_ff[k] <= st_ff[k-1];
         x_ff[k]    <= x_in;
         st_b_ff[k] <= st_a_ff[k];
         xb_ff[k]   <= x_ff[k];
         y_ff[k]    <= 63'(x_ff[k]) * 63'(RECIP);
         st_ff[k]   <= st_in;
      end
   end

   for (genvar j = 1; j < EXP_SAT; j++) begin : g_pow
      exp_state_type src;
      exp_state_type pw_in;
      logic [61:0]   prod;

      if (j == 1) begin : g_first
         assign src = st_ff[TAYLOR_TERMS];
      end else begin : g_next
         assign src = pw_ff[j-1];
      end

      always_comb begin
         prod  = 62'(src.sum) * 62'(INV_E_Q30);
         pw_in = src;
         if (src.n > 6'(j - 1)) begin
            pw_in.sum = prod[61:30];
         end
      end

      always_ff @(posedge clock) begin
         pw_ff[j] <= pw_in;
      end
   end

   assign result = pw_ff[EXP_SAT-1].z ? 31'd0 : pw_ff[EXP_SAT-1].sum[30:0];

endmodule
`default_nettype wire

>>> design/wts_lobe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_lobe
// One two-sided Gaussian lobe of the colour matching fit: distance to the
// centre, scaled argument, square and exponential, result in Q16.
// ----------------------------------------------------------------------------
module wts_lobe
   import wts_pkg::*;
(
   input  logic           clock,
   input  logic [13:0]    wavelength,
   input  logic [12:0]    centre,
   input  logic [9:0]     k_below,
   input  logic [9:0]     k_above,
   output q_unsigned_type lobe
);

   localparam logic [21:0] RECIP_3125 = 22'((64'd1 << 33) / 64'd3125);

   logic [13:0]    dmag_ff;
   logic [9:0]     k_ff;
   logic [21:0]    m_ff;
   logic [32:0]    num_ff;
   logic [54:0]    y_ff;
   logic [20:0]    t_ff;
   logic [41:0]    sq_ff;
   q_unsigned_type lobe_ff;

   logic [13:0]    dmag_in;
   logic [9:0]     k_in;
   logic [32:0]    num_in;
   logic [21:0]    q0;
   logic [32:0]    rem;
   logic [20:0]    t_in;
   logic [42:0]    a_wide;
   logic [ARG_W-1:0] arg;
   logic [30:0]    e;
   q_unsigned_type lobe_in;

   always_comb begin
      if (wavelength < {1'b0, centre}) begin
         dmag_in = {1'b0, centre} - wavelength;
         k_in    = k_below;
      end else begin
         dmag_in = wavelength - {1'b0, centre};
         k_in    = k_above;
      end
      num_in  = {m_ff, 11'd0} + 33'd1562;
      q0      = y_ff[54:33];
      rem     = num_ff - 33'(q0) * 33'd3125;
      t_in    = 21'(q0 + 22'(rem >= 33'd3125));
      a_wide  = (43'(sq_ff) + 43'(64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
      arg     = ARG_W'({a_wide[25:0], 14'd0});
      lobe_in = 17'((32'(e) + 32'(64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      dmag_ff <= dmag_in;
      k_ff    <= k_in;
      m_ff    <= 22'(24'(dmag_ff) * 24'(k_ff));
      num_ff  <= num_in;
      y_ff    <= 55'(num_in) * 55'(RECIP_3125);
      t_ff    <= t_in;
      sq_ff   <= 42'(t_ff) * 42'(t_ff);
      lobe_ff <= lobe_in;
   end

   wts_exp u_exp (
      .clock  (clock),
      .arg    (arg),
      .result (e)
   );

   assign lobe = lobe_ff;

endmodule
`default_nettype wire

>>> design/wts_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_mix
// Weighted lobe sums to CIE XYZ, then XYZ to linear sRGB, each rounded and
// the result clamped to 0..1 in Q16.
// ----------------------------------------------------------------------------
module wts_mix
   import wts_pkg::*;
(
   input  logic           clock,
   input  q_unsigned_type lobe [0:NUM_LOBES-1],
   output q_unsigned_type lin  [0:2]
);

   localparam logic [18:0] RECIP_1000 = 19'((64'd1 << 28) / 64'd1000);
   localparam logic [20:0] RECIP_1E7  = 21'((64'd1 << 44) / 64'd10000000);

   logic signed [30:0] lw [0:NUM_LOBES-1];
   logic signed [30:0] sxyz_ff [0:2];
   logic               xneg_ff [0:2];
   logic [27:0]        xmag_ff [0:2];
   logic [46:0]        xy_ff   [0:2];
   logic signed [17:0] xyz_ff  [0:2];
   logic signed [46:0] srgb_ff [0:2];
   logic               rneg_ff [0:2];
   logic [44:0]        rmag_ff [0:2];
   logic [65:0]        ry_ff   [0:2];
   q_unsigned_type     lin_ff  [0:2];

   for (genvar i = 0; i < NUM_LOBES; i++) begin : g_w
      assign lw[i] = 31'(LOBE_WEIGHT[i]) * $signed({14'd0, lobe[i]});
   end

   for (genvar c = 0; c < 3; c++) begin : g_ch
      logic signed [30:0] sxyz_in;
      logic [27:0]        xmag_in;
      logic [18:0]        xq0;
      logic [27:0]        xrem;
      logic [17:0]        xq;
      logic signed [46:0] srgb_in;
      logic [44:0]        rmag_in;
      logic [21:0]        rq0;
      logic [44:0]        rrem;
      logic [21:0]        rq;
      q_unsigned_type     lin_in;

      always_comb begin
         case (c)
            0:       sxyz_in = lw[0] + lw[1] + lw[2];
            1:       sxyz_in = lw[3] + lw[4];
            default: sxyz_in = lw[5] + lw[6];
         endcase
         xmag_in = (sxyz_ff[c] < 0) ? 28'(-sxyz_ff[c]) + 28'd500
                                    : 28'(sxyz_ff[c]) + 28'd500;
         xq0     = xy_ff[c][46:28];
         xrem    = xmag_ff[c] - 28'(xq0) * 28'd1000;
         xq      = 18'(xq0) + 18'(xrem >= 28'd1000);
         srgb_in = 47'(RGB_MATRIX[c][0]) * 47'(xyz_ff[0])
                 + 47'(RGB_MATRIX[c][1]) * 47'(xyz_ff[1])
                 + 47'(RGB_MATRIX[c][2]) * 47'(xyz_ff[2]);
         rmag_in = (srgb_ff[c] < 0) ? 45'(-srgb_ff[c]) + 45'd5000000
                                    : 45'(srgb_ff[c]) + 45'd5000000;
         rq0     = ry_ff[c][65:44];
         rrem    = rmag_ff[c] - 45'(rq0) * 45'd10000000;
         rq      = rq0 + 22'(rrem >= 45'd10000000);
         if (rneg_ff[c]) begin
            lin_in = '0;
         end else if (rq > 22'(ONE_Q)) begin
            lin_in = ONE_Q;
         end else begin
            lin_in = 17'(rq);
         end
      end

      always_ff @(posedge clock) begin
         sxyz_ff[c] <= sxyz_in;
         xneg_ff[c] <= sxyz_ff[c] < 0;
         xmag_ff[c] <= xmag_in;
         xy_ff[c]   <= 47'(xmag_in) * 47'(RECIP_1000);
         xyz_ff[c]  <= xneg_ff[c] ? -$signed(xq) : $signed(xq);
         srgb_ff[c] <= srgb_in;
         rneg_ff[c] <= srgb_ff[c] < 0;
         rmag_ff[c] <= rmag_in;
         ry_ff[c]   <= 66'(rmag_in) * 66'(RECIP_1E7);
         lin_ff[c]  <= lin_in;
      end

      assign lin[c] = lin_ff[c];
   end

endmodule
`default_nettype wire

>>> design/wts_enc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_enc
// sRGB transfer curve for one channel: linear segment near black, otherwise
// x^(1/2.4) via a bit-serial log2 and an exponential, scaled to 8 bits.
// ----------------------------------------------------------------------------
module wts_enc
   import wts_pkg::*;
(
   input  logic           clock,
   input  q_unsigned_type lin,
   output logic [7:0]     code
);

   localparam logic [32:0] RECIP_3   = 33'((64'd1 << 34) / 64'd3);
   localparam logic [9:0]  RECIP_1000 = 10'((64'd1 << 19) / 64'd1000);

   root_state_type rs_ff [0:ROOT_STEPS];
   knee_type       kn_ff [1:ENC_LAT-1];
   logic [33:0]    v4_ff;
   logic [66:0]    y3_ff;
   logic [32:0]    q_ff;
   logic [ARG_W-1:0] arg_ff;
   logic [18:0]    v_ff;
   logic [18:0]    vb_ff;
   logic [28:0]    yv_ff;
   logic [7:0]     code_ff;

   logic [4:0]     msb;
   root_state_type rs0_in;
   knee_type       kn_in;
   logic [39:0]    lin_scaled;
   logic [34:0]    l_val;
   logic [37:0]    v_val;
   logic [33:0]    v4_in;
   logic [32:0]    q0;
   logic [34:0]    q_rem;
   logic [32:0]    q_in;
   logic [62:0]    a_prod;
   logic [30:0]    r;
   logic [49:0]    num;
   logic [18:0]    v_in;
   logic [9:0]     cq0;
   logic [19:0]    c_rem;
   logic [9:0]     cq;
   logic [7:0]     gamma;
   logic [14:0]    low_prod;
   logic [7:0]     code_in;

   always_comb begin
      msb = '0;
      for (int i = 0; i < 17; i++) begin
         if (lin[i]) begin
            msb = 5'(i);
         end
      end
      rs0_in.e    = 5'd16 - msb;
      rs0_in.m    = 31'({lin, 14'd0}) << rs0_in.e;
      rs0_in.bits = '0;
      lin_scaled  = 40'(lin) * 40'd65892 + 40'(10 * (64'd1 << FRAC_BITS));
      kn_in.knee    = lin <= LIN_KNEE;
      kn_in.lin_pre = lin_scaled[24:17];
   end

   always_ff @(posedge clock) begin
      rs_ff[0] <= rs0_in;
      kn_ff[1] <= kn_in;
   end

   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_sq
      logic [61:0]    sq;
      root_state_type rs_in;

      always_comb begin
         sq    = 62'(rs_ff[i].m) * 62'(rs_ff[i].m);
         rs_in = rs_ff[i];
         if (sq[61]) begin
            rs_in.m = sq[61:31];
            rs_in.bits[ROOT_STEPS-1-i] = 1'b1;
         end else begin
            rs_in.m = sq[60:30];
         end
      end

      always_ff @(posedge clock) begin
         rs_ff[i+1] <= rs_in;
      end
   end

   for (genvar i = 2; i < ENC_LAT; i++) begin : g_knee
      always_ff @(posedge clock) begin
         kn_ff[i] <= kn_ff[i-1];
      end
   end

   always_comb begin
      l_val  = {rs_ff[ROOT_STEPS].e, 30'd0} - 35'(rs_ff[ROOT_STEPS].bits);
      v_val  = 38'(l_val) * 38'd5 + 38'd6;
      v4_in  = v_val[35:2];
      q0     = y3_ff[66:34];
      q_rem  = 35'(v4_ff) - 35'(q0) * 35'd3;
      q_in   = q0 + 33'(q_rem >= 35'd3);
      a_prod = 63'(q_ff) * 63'(LN2_Q30);
      num    = 50'(r) * 50'd269025;
      if (num < (50'd14025 << 30)) begin
         v_in = '0;
      end else begin
         v_in = 19'((num - (50'd14025 << 30)) >> 30) + 19'd500;
      end
      cq0    = yv_ff[28:19];
      c_rem  = 20'(vb_ff) - 20'(cq0) * 20'd1000;
      cq     = cq0 + 10'(c_rem >= 20'd1000);
      gamma  = (cq > 10'd255) ? 8'd255 : cq[7:0];
      low_prod = 15'(kn_ff[ENC_LAT-1].lin_pre) * 15'd205;
      code_in  = kn_ff[ENC_LAT-1].knee ? 8'(low_prod[14:11]) : gamma;
   end

   always_ff @(posedge clock) begin
      v4_ff   <= v4_in;
      y3_ff   <= 67'(v4_in) * 67'(RECIP_3);
      q_ff    <= q_in;
      arg_ff  <= ARG_W'(a_prod[62:30]);
      v_ff    <= v_in;
      vb_ff   <= v_ff;
      yv_ff   <= 29'(v_ff) * 29'(RECIP_1000);
      code_ff <= code_in;
   end

   wts_exp u_exp (
      .clock  (clock),
      .arg    (arg_ff),
      .result (r)
   );

   assign code = code_ff;

endmodule
`default_nettype wire

>>> design/wavelength_to_srgb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavelength_to_srgb
// Wavelength in tenths of a nanometre to a gamma-encoded 8-bit sRGB triple.
//
// Raise start with req_wavelength_tenths_nm for one cycle per transaction;
// busy is always low, so a new wavelength may be issued every clock cycle.
// Wavelengths outside 300.0 .. 900.0 nm are saturated to the nearest end.
// Each result appears on rsp_red, rsp_green and rsp_blue for one cycle,
// marked by rsp_strobe, in issue order.
// Throughput is one transaction per cycle.
// The pipeline depth is set by the pipelined exponential (79 stages), used once
// in each lobe and once in each channel's transfer curve, and by the
// 30-stage bit-serial log2 of the transfer curve.
// Synchronous reset clears the strobe pipeline only; transactions in
// flight are dropped and no strobe follows until new starts arrive.
// The receiver cannot stall; results must be taken when strobed.
// ----------------------------------------------------------------------------
module wavelength_to_srgb
   import wts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [13:0] req_wavelength_tenths_nm,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);

   logic [TOTAL_LAT-1:0] vld_ff;
   logic [TOTAL_LAT-1:0] vld_in;
   logic [13:0]          w_ff;
   logic [13:0]          w_in;
   q_unsigned_type       lobe [0:NUM_LOBES-1];
   q_unsigned_type       lin  [0:2];
   logic [7:0]           code [0:2];

   always_comb begin
      if (req_wavelength_tenths_nm < W_MIN) begin
         w_in = W_MIN;
      end else if (req_wavelength_tenths_nm > W_MAX) begin
         w_in = W_MAX;
      end else begin
         w_in = req_wavelength_tenths_nm;
      end
      vld_in = {vld_ff[TOTAL_LAT-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   for (genvar i = 0; i < NUM_LOBES; i++) begin : g_lobe
      wts_lobe u_lobe (
         .clock      (clock),
         .wavelength (w_ff),
         .centre     (LOBE_CENTRE[i]),
         .k_below    (LOBE_K_BELOW[i]),
         .k_above    (LOBE_K_ABOVE[i]),
         .lobe       (lobe[i])
      );
   end

   wts_mix u_mix (
      .clock (clock),
      .lobe  (lobe),
      .lin   (lin)
   );

   for (genvar c = 0; c < 3; c++) begin : g_enc
      wts_enc u_enc (
         .clock (clock),
         .lin   (lin[c]),
         .code  (code[c])
      );
   end

   assign busy       = 1'b0;
   assign rsp_strobe = vld_ff[TOTAL_LAT-1];
   assign rsp_red    = code[0];
   assign rsp_green  = code[1];
   assign rsp_blue   = code[2];

endmodule
`default_nettype wire

>>> tb/wavelength_to_srgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavelength_to_srgb_checker
// Watches the wavelength and colour channels of the converter, computes the
// expected sRGB triple for every accepted wavelength and compares each strobed
// result, in order, against the oldest pending triple.
// ----------------------------------------------------------------------------
module wavelength_to_srgb_checker
   import wts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [13:0] req_wavelength_tenths_nm,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   output int          fail_count,
   output int          pending_count,
   output int          colour_count
);

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   colour_type pending_colours[$];

   localparam longint unsigned Q30_ONE = 64'd1 << 30;

   function automatic longint rounded_div(longint num, longint den);
      if (num >= 0) begin
         return (num + den / 2) / den;
      end
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint unsigned decay_q30(longint unsigned arg);
      longint unsigned whole, frac, acc, term;
      whole = arg >> 30;
      frac  = arg & (Q30_ONE - 1);
      acc   = Q30_ONE;
      term  = Q30_ONE;
      if (whole >= EXP_SAT) begin
         return 0;
      end
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = ((term * frac) >> 30) / k;
         if (k % 2 == 1) begin
            acc = (term > acc) ? 0 : acc - term;
         end else begin
            acc = acc + term;
         end
      end
      while (whole > 0 && acc != 0) begin
         acc = (acc * INV_E_Q30) >> 30;
         whole--;
      end
      return acc;
   endfunction

   function automatic longint lobe_height(longint w, int idx);
      longint d, k, t;
      longint unsigned mag, a, e;
      d = w - LOBE_CENTRE[idx];
      k = (w < LOBE_CENTRE[idx]) ? LOBE_K_BELOW[idx] : LOBE_K_ABOVE[idx];
      t = rounded_div(d * k * (64'sd1 <<< FRAC_BITS), 100000);
      mag = (t < 0) ? -t : t;
      a = (mag * mag + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
      e = decay_q30(a << (30 - FRAC_BITS));
      return (e + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   endfunction

   function automatic longint unsigned gamma_root_q30(longint unsigned x);
      longint unsigned m, bits, lg, q;
      int ex;
      m = x;
      bits = 0;
      ex = 0;
      while (m < Q30_ONE) begin
         m = m << 1;
         ex++;
      end
      for (int i = 0; i < ROOT_STEPS; i++) begin
         m = (m * m) >> 30;
         if (m >= (Q30_ONE << 1)) begin
            m = m >> 1;
            bits = bits | (64'd1 << (29 - i));
         end
      end
      lg = (longint'(ex) << 30) - bits;
      q = (lg * 5 + 6) / 12;
      return decay_q30((q * LN2_Q30) >> 30);
   endfunction

   function automatic logic [7:0] gamma_code(longint lin);
      longint unsigned x, r, code;
      longint num;
      if (lin < 0) lin = 0;
      if (lin > (64'sd1 <<< FRAC_BITS)) lin = 64'sd1 <<< FRAC_BITS;
      x = lin;
      if (x * 10000000 <= (64'd31308 << FRAC_BITS)) begin
         code = (2 * x * 32946 + (64'd10 << FRAC_BITS)) / (64'd20 << FRAC_BITS);
      end else begin
         r = gamma_root_q30(x << (30 - FRAC_BITS));
         num = longint'(r * 269025) - longint'(14025 * Q30_ONE);
         if (num < 0) num = 0;
         code = (longint'(num) + 500 * Q30_ONE) / (1000 * Q30_ONE);
      end
      return (code > 255) ? 8'd255 : code[7:0];
   endfunction

   function automatic colour_type predict_colour(logic [13:0] raw);
      longint w, h[NUM_LOBES], cie[3], lin;
      colour_type c;
      w = (raw < W_MIN) ? W_MIN : (raw > W_MAX) ? W_MAX : raw;
      for (int i = 0; i < NUM_LOBES; i++) h[i] = lobe_height(w, i);
      cie[0] = rounded_div(LOBE_WEIGHT[0] * h[0] + LOBE_WEIGHT[1] * h[1]
                           + LOBE_WEIGHT[2] * h[2], 1000);
      cie[1] = rounded_div(LOBE_WEIGHT[3] * h[3] + LOBE_WEIGHT[4] * h[4], 1000);
      cie[2] = rounded_div(LOBE_WEIGHT[5] * h[5] + LOBE_WEIGHT[6] * h[6], 1000);
      for (int ch = 0; ch < 3; ch++) begin
         lin = rounded_div(RGB_MATRIX[ch][0] * cie[0] + RGB_MATRIX[ch][1] * cie[1]
                           + RGB_MATRIX[ch][2] * cie[2], 10000000);
         if (ch == 0) c.red = gamma_code(lin);
         else if (ch == 1) c.green = gamma_code(lin);
         else c.blue = gamma_code(lin);
      end
      return c;
   endfunction

   initial begin
      fail_count    = 0;
      colour_count  = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      colour_type want;
      if (!reset) begin
         if (start && !busy) begin
            pending_colours.push_back(predict_colour(req_wavelength_tenths_nm));
         end
         if (rsp_strobe) begin
            colour_count++;
            if (pending_colours.size() == 0) begin
               $error("unexpected colour %0d %0d %0d", rsp_red, rsp_green, rsp_blue);
               fail_count++;
            end else begin
               want = pending_colours.pop_front();
               if (rsp_red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_red);
                  fail_count++;
               end
               if (rsp_green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_green);
                  fail_count++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
                  fail_count++;
               end
            end
         end
      end
      pending_count = pending_colours.size();
   end

endmodule

>>> tb/wavelength_to_srgb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavelength_to_srgb_tb
// Drives directed and random wavelengths into the converter in bursts with
// random gaps and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module wavelength_to_srgb_tb;
   import wts_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [13:0] req_wavelength_tenths_nm = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_red, rsp_green, rsp_blue;
   int          fail_count, pending_count, colour_count;
   int          cycle_count = 0;
   int          sent_count = 0;

   always #6 clock = ~clock;

   wavelength_to_srgb dut (.*);

   wavelength_to_srgb_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("wavelength_to_srgb_tb: FAIL");
         $finish;
      end
   end

   // issue one transaction, holding start across back-to-back items
   task automatic send_wavelength(logic [13:0] w);
      start <= 1'b1;
      req_wavelength_tenths_nm <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic [13:0] pick_wavelength();
      case ($urandom_range(0, 9))
         0: return 14'($urandom());
         1: return 14'($urandom_range(0, 3000));
         2: return 14'($urandom_range(9000, 16383));
         3: return 14'($urandom_range(4300, 4600));
         default: return 14'($urandom_range(3000, 9000));
      endcase
   endfunction

   initial begin
      logic [13:0] directed[$];
      int burst, gap, left;
      directed = '{14'd0, 14'd1, 14'd2999, 14'd3000, 14'd3001, 14'd3800, 14'd4370,
                   14'd4420, 14'd4590, 14'd5011, 14'd5309, 14'd5688, 14'd5998,
                   14'd6500, 14'd7000, 14'd7800, 14'd8999, 14'd9000, 14'd9001,
                   14'h2AAA, 14'h1555, 14'h3FFF};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_wavelength(directed[i]);
      left = RANDOM_ITEMS;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && left > 0; i++) begin
            left--;
            send_wavelength(pick_wavelength());
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start <= 1'b0;
      while (pending_count > 0) @(posedge clock);
      repeat (TOTAL_LAT + 20) @(posedge clock);
      $display("sent %0d wavelengths, checked %0d colour triples", sent_count,
               colour_count);
      if (fail_count == 0) begin
         $display("wavelength_to_srgb_tb: PASS");
      end else begin
         $display("wavelength_to_srgb_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
design/wts_pkg.sv
design/wts_exp.sv
design/wts_lobe.sv
design/wts_mix.sv
design/wts_enc.sv
design/wavelength_to_srgb.sv
tb/wavelength_to_srgb_checker.sv
tb/wavelength_to_srgb_tb.sv
